@@ rtl/core/bbu_pkg.sv @@
// Shared types and constants for the block bilinear upscaler.
// No dependencies; imported by every module in rtl/core.
`default_nettype none

package bbu_pkg;

	localparam int DST_BLOCK_DEF = 16;
	localparam int SIZE_W        = 5;
	localparam int POS_W         = 4;
	localparam int PIX_W         = 8;
	localparam int IDX_W         = 4;
	localparam int CFG_IDX_W     = 1;
	localparam int RECIP_SHIFT   = 16;

	typedef logic [PIX_W-1:0]     pix_t;
	typedef logic [POS_W-1:0]     pos_t;
	typedef logic [IDX_W-1:0]     idx_t;
	typedef logic [SIZE_W-1:0]    size_t;
	typedef logic [CFG_IDX_W-1:0] cfg_index_t;

	localparam cfg_index_t CFG_SRC_BLOCK_WIDTH  = 1'b0;
	localparam cfg_index_t CFG_SRC_BLOCK_HEIGHT = 1'b1;
	localparam size_t      SIZE_RESET           = 5'd16;

	// per-stage load enables
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
		logic s5;
		logic s6;
	} stage_en_t;

endpackage

`default_nettype wire

@@ rtl/core/bbu_axis_map.sv @@
// One axis of the position mapping: clamp, product, reciprocal divide by DST_BLOCK.
// Stages 1 to 3; depends on bbu_pkg.
`default_nettype none

module bbu_axis_map #(
	parameter int DST_BLOCK = bbu_pkg::DST_BLOCK_DEF
) (
	input  wire logic               clk,
	input  wire bbu_pkg::stage_en_t en,
	input  wire bbu_pkg::pos_t      pos,
	input  wire bbu_pkg::size_t     size_raw,
	output bbu_pkg::idx_t           idx,
	output logic [$clog2(DST_BLOCK)-1:0] rem
);
	import bbu_pkg::*;

	localparam int SW  = $clog2(DST_BLOCK + 1);
	localparam int RW  = $clog2(DST_BLOCK);
	localparam int CW  = (SW > SIZE_W) ? SW : SIZE_W;
	localparam int PW  = POS_W + SW;
	localparam int LO  = DST_BLOCK / 3;
	localparam int RK  = RECIP_SHIFT;
	localparam int MUL = (1 << RK) / DST_BLOCK;

	localparam logic [CW-1:0] LO_C  = CW'(LO);
	localparam logic [CW-1:0] HI_C  = CW'(DST_BLOCK);
	localparam logic [PW-1:0] DST_P = PW'(DST_BLOCK);
	localparam logic [RK-1:0] MUL_C = RK'(MUL);

	logic [POS_W-1:0] pos_mod_tbl [16];

	for (genvar i = 0; i < 16; i++) begin : g_mod
		assign pos_mod_tbl[i] = POS_W'(i % DST_BLOCK);
	end

	logic [CW-1:0]    size_ext;
	logic [SW-1:0]    size_c;
	logic [PW-1:0]    prod_s1;
	logic [PW-1:0]    prod_s2;
	logic [PW-1:0]    qe_s2;
	logic [PW+RK-1:0] scaled;
	logic [PW-1:0]    base;
	logic [PW-1:0]    rem_raw;
	idx_t             idx_s3;
	logic [RW-1:0]    rem_s3;

	assign size_ext = CW'(size_raw);

	always_comb begin
		priority if (size_ext < LO_C) begin
			size_c = SW'(LO_C);
		end else if (size_ext > HI_C) begin
			size_c = SW'(HI_C);
		end else begin
			size_c = SW'(size_ext);
		end
	end

	// quotient estimate is exact or one low
	assign scaled  = (PW+RK)'(prod_s1) * (PW+RK)'(MUL_C);
	assign base    = PW'(qe_s2 * DST_P);
	assign rem_raw = prod_s2 - base;

	always_ff @(posedge clk) begin
		if (en.s1) begin
			prod_s1 <= PW'(pos_mod_tbl[pos]) * PW'(size_c);
		end
		if (en.s2) begin
			prod_s2 <= prod_s1;
			qe_s2   <= PW'(scaled >> RK);
		end
		if (en.s3) begin
			if (rem_raw >= DST_P) begin
				idx_s3 <= IDX_W'(qe_s2 + PW'(1));
				rem_s3 <= RW'(rem_raw - DST_P);
			end else begin
				idx_s3 <= IDX_W'(qe_s2);
				rem_s3 <= RW'(rem_raw);
			end
		end
	end

	assign idx = idx_s3;
	assign rem = rem_s3;

endmodule

`default_nettype wire

@@ rtl/core/bbu_blend.sv @@
// Bilinear weighting of the four neighbour pixels, stages 1 to 6.
// Pixels are delayed to meet the axis remainders at stage 3; depends on bbu_pkg.
`default_nettype none

module bbu_blend #(
	parameter int DST_BLOCK = bbu_pkg::DST_BLOCK_DEF
) (
	input  wire logic                    clk,
	input  wire bbu_pkg::stage_en_t      en,
	input  wire bbu_pkg::pix_t           pix_ul,
	input  wire bbu_pkg::pix_t           pix_ur,
	input  wire bbu_pkg::pix_t           pix_dl,
	input  wire bbu_pkg::pix_t           pix_dr,
	input  wire logic [$clog2(DST_BLOCK)-1:0] rem_col,
	input  wire logic [$clog2(DST_BLOCK)-1:0] rem_row,
	output bbu_pkg::pix_t                pixel_out
);
	import bbu_pkg::*;

	localparam int WW   = $clog2(DST_BLOCK + 1);
	localparam int W2   = 2 * WW;
	localparam int TW   = W2 + PIX_W;
	localparam int SUMW = TW + 2;
	localparam int SH   = 2 * (WW - 1);

	localparam logic [WW-1:0] DST_W = WW'(DST_BLOCK);

	pix_t ul_s1, ur_s1, dl_s1, dr_s1;
	pix_t ul_s2, ur_s2, dl_s2, dr_s2;
	pix_t ul_s3, ur_s3, dl_s3, dr_s3;
	pix_t ul_s4, ur_s4, dl_s4, dr_s4;

	logic [WW-1:0] lw, rw, uw, dw;
	logic [W2-1:0] w_ul_s4, w_ur_s4, w_dl_s4, w_dr_s4;
	logic [TW-1:0] t_ul_s5, t_ur_s5, t_dl_s5, t_dr_s5;
	logic [SUMW-1:0] sum;
	pix_t          pixel_s6;

	assign rw = WW'(rem_col);
	assign lw = DST_W - rw;
	assign dw = WW'(rem_row);
	assign uw = DST_W - dw;

	assign sum = SUMW'(t_ul_s5) + SUMW'(t_ur_s5) + SUMW'(t_dl_s5) + SUMW'(t_dr_s5);

	always_ff @(posedge clk) begin
		if (en.s1) begin
			ul_s1 <= pix_ul;
			ur_s1 <= pix_ur;
			dl_s1 <= pix_dl;
			dr_s1 <= pix_dr;
		end
		if (en.s2) begin
			ul_s2 <= ul_s1;
			ur_s2 <= ur_s1;
			dl_s2 <= dl_s1;
			dr_s2 <= dr_s1;
		end
		if (en.s3) begin
			ul_s3 <= ul_s2;
			ur_s3 <= ur_s2;
			dl_s3 <= dl_s2;
			dr_s3 <= dr_s2;
		end
		if (en.s4) begin
			ul_s4   <= ul_s3;
			ur_s4   <= ur_s3;
			dl_s4   <= dl_s3;
			dr_s4   <= dr_s3;
			w_ul_s4 <= W2'(uw) * W2'(lw);
			w_ur_s4 <= W2'(uw) * W2'(rw);
			w_dl_s4 <= W2'(dw) * W2'(lw);
			w_dr_s4 <= W2'(dw) * W2'(rw);
		end
		if (en.s5) begin
			t_ul_s5 <= TW'(w_ul_s4) * TW'(ul_s4);
			t_ur_s5 <= TW'(w_ur_s4) * TW'(ur_s4);
			t_dl_s5 <= TW'(w_dl_s4) * TW'(dl_s4);
			t_dr_s5 <= TW'(w_dr_s4) * TW'(dr_s4);
		end
		if (en.s6) begin
			pixel_s6 <= sum[SH +: PIX_W];
		end
	end

	assign pixel_out = pixel_s6;

endmodule

`default_nettype wire

@@ rtl/core/block_bilinear_upscaler_top.sv @@
// Top level of the block bilinear upscaler: config registers, stage valids, stall chain.
// Depends on bbu_pkg, bbu_axis_map and bbu_blend.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  cfg     | cfg_wr_en, cfg_index, cfg_data            | in
//  in      | in_valid/in_stall, out_col .. pix_down_right | in
//  out     | out_valid/out_stall, pixel_out, src_col, src_row | out
//
// Six-stage pipeline, one pixel per clock unless out_stall holds it; an input transfer
// moves through stages 1 to 6 in order, and out_valid rises when it reaches stage 6.
// The stage depth is set by the reciprocal divide (stages 1-3) and the weight multiplies (4-6).
// Each stage loads when it is empty or the next stage moves, so bubbles are squeezed out.
// Reset clears stage valids and sets both source sizes to 16.
`default_nettype none

module block_bilinear_upscaler_top #(
	parameter int DST_BLOCK = bbu_pkg::DST_BLOCK_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_wr_en,
	input  wire bbu_pkg::cfg_index_t cfg_index,
	input  wire bbu_pkg::size_t      cfg_data,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire bbu_pkg::pos_t       out_col,
	input  wire bbu_pkg::pos_t       out_row,
	input  wire bbu_pkg::pix_t       pix_up_left,
	input  wire bbu_pkg::pix_t       pix_up_right,
	input  wire bbu_pkg::pix_t       pix_down_left,
	input  wire bbu_pkg::pix_t       pix_down_right,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output bbu_pkg::pix_t            pixel_out,
	output bbu_pkg::idx_t            src_col,
	output bbu_pkg::idx_t            src_row
);
	import bbu_pkg::*;

	localparam int RW = $clog2(DST_BLOCK);

	size_t     src_block_width_q;
	size_t     src_block_height_q;
	stage_en_t en;
	logic      vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	idx_t      col_idx, row_idx;
	idx_t      col_idx_s4, col_idx_s5, col_idx_s6;
	idx_t      row_idx_s4, row_idx_s5, row_idx_s6;
	logic [RW-1:0] col_rem, row_rem;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_block_width_q  <= SIZE_RESET;
			src_block_height_q <= SIZE_RESET;
		end else if (cfg_wr_en) begin
			if (cfg_index == CFG_SRC_BLOCK_WIDTH) begin
				src_block_width_q <= cfg_data;
			end else if (cfg_index == CFG_SRC_BLOCK_HEIGHT) begin
				src_block_height_q <= cfg_data;
			end
		end
	end

	// a stage loads when empty or when its successor moves
	assign en.s6 = !vld_s6 || !out_stall;
	assign en.s5 = !vld_s5 || en.s6;
	assign en.s4 = !vld_s4 || en.s5;
	assign en.s3 = !vld_s3 || en.s4;
	assign en.s2 = !vld_s2 || en.s3;
	assign en.s1 = !vld_s1 || en.s2;

	assign in_stall = !en.s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else begin
			if (en.s1) vld_s1 <= in_valid;
			if (en.s2) vld_s2 <= vld_s1;
			if (en.s3) vld_s3 <= vld_s2;
			if (en.s4) vld_s4 <= vld_s3;
			if (en.s5) vld_s5 <= vld_s4;
			if (en.s6) vld_s6 <= vld_s5;
		end
	end

	bbu_axis_map #(.DST_BLOCK(DST_BLOCK)) u_map_col (
		.clk      (clk),
		.en       (en),
		.pos      (out_col),
		.size_raw (src_block_width_q),
		.idx      (col_idx),
		.rem      (col_rem)
	);

	bbu_axis_map #(.DST_BLOCK(DST_BLOCK)) u_map_row (
		.clk      (clk),
		.en       (en),
		.pos      (out_row),
		.size_raw (src_block_height_q),
		.idx      (row_idx),
		.rem      (row_rem)
	);

	bbu_blend #(.DST_BLOCK(DST_BLOCK)) u_blend (
		.clk       (clk),
		.en        (en),
		.pix_ul    (pix_up_left),
		.pix_ur    (pix_up_right),
		.pix_dl    (pix_down_left),
		.pix_dr    (pix_down_right),
		.rem_col   (col_rem),
		.rem_row   (row_rem),
		.pixel_out (pixel_out)
	);

	always_ff @(posedge clk) begin
		if (en.s4) begin
			col_idx_s4 <= col_idx;
			row_idx_s4 <= row_idx;
		end
		if (en.s5) begin
			col_idx_s5 <= col_idx_s4;
			row_idx_s5 <= row_idx_s4;
		end
		if (en.s6) begin
			col_idx_s6 <= col_idx_s5;
			row_idx_s6 <= row_idx_s5;
		end
	end

	assign out_valid = vld_s6;
	assign src_col   = col_idx_s6;
	assign src_row   = row_idx_s6;

endmodule

`default_nettype wire

@@ verif/tb_top.sv @@
// Self-checking testbench for block_bilinear_upscaler_top: random and directed pixels,
// a scoreboard class that predicts the mapped indices and the interpolated pixel.
// Depends on bbu_pkg and the RTL under rtl/core; nothing else.
module tb_top;
	import bbu_pkg::*;

	localparam int DST = DST_BLOCK_DEF;
	localparam int SUM_SHIFT = 2 * $clog2(DST);
	localparam int CYCLE_LIMIT = 300000;
	localparam int PHASE_ITEMS = 205;

	typedef struct {
		pix_t pixel;
		idx_t col;
		idx_t row;
	} upscale_result_t;

	class upscale_scoreboard;
		size_t width_reg;
		size_t height_reg;
		upscale_result_t pending[$];
		int errors;

		function new();
			width_reg = SIZE_RESET;
			height_reg = SIZE_RESET;
			errors = 0;
		endfunction

		function void write_reg(cfg_index_t index, size_t value);
			if (index == CFG_SRC_BLOCK_WIDTH) begin
				width_reg = value;
			end else begin
				height_reg = value;
			end
		endfunction

		// size in use is held to DST/3 .. DST; the register keeps its raw bits
		static function int unsigned clamp_size(size_t s);
			if (s < DST / 3) return DST / 3;
			if (s > DST) return DST;
			return s;
		endfunction

		static function void map_axis(pos_t pos, size_t s, output idx_t idx,
				output int unsigned weight);
			int unsigned prod;
			prod = (pos % DST) * clamp_size(s);
			idx = idx_t'(prod / DST);
			weight = DST - prod % DST;
		endfunction

		function void note_transfer(pos_t col, pos_t row, pix_t ul, pix_t ur,
				pix_t dl, pix_t dr);
			upscale_result_t r;
			int unsigned hw;
			int unsigned vw;
			int unsigned sum;
			map_axis(col, width_reg, r.col, hw);
			map_axis(row, height_reg, r.row, vw);
			sum = vw * hw * ul + vw * (DST - hw) * ur
				+ (DST - vw) * hw * dl + (DST - vw) * (DST - hw) * dr;
			r.pixel = pix_t'(sum >> SUM_SHIFT);
			pending.push_back(r);
		endfunction

		function void check_result(pix_t pixel, idx_t col, idx_t row);
			upscale_result_t r;
			if (pending.size() == 0) begin
				$error("unexpected result: pixel_out %0d src_col %0d src_row %0d",
					pixel, col, row);
				errors++;
				return;
			end
			r = pending.pop_front();
			if (pixel !== r.pixel) begin
				$error("pixel_out: expected %0d, got %0d", r.pixel, pixel);
				errors++;
			end
			if (col !== r.col) begin
				$error("src_col: expected %0d, got %0d", r.col, col);
				errors++;
			end
			if (row !== r.row) begin
				$error("src_row: expected %0d, got %0d", r.row, row);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	cfg_index_t cfg_index = CFG_SRC_BLOCK_WIDTH;
	size_t cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	pos_t out_col = '0;
	pos_t out_row = '0;
	pix_t pix_up_left = '0;
	pix_t pix_up_right = '0;
	pix_t pix_down_left = '0;
	pix_t pix_down_right = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	pix_t pixel_out;
	idx_t src_col;
	idx_t src_row;

	int send_idle_pct = 26;
	int recv_stall_pct = 59;
	int cycle_count = 0;
	upscale_scoreboard sb;

	block_bilinear_upscaler_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.out_col(out_col),
		.out_row(out_row),
		.pix_up_left(pix_up_left),
		.pix_up_right(pix_up_right),
		.pix_down_left(pix_down_left),
		.pix_down_right(pix_down_right),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.pixel_out(pixel_out),
		.src_col(src_col),
		.src_row(src_row)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb_top failed");
			$finish;
		end
	end

	// output side: check each transfer, stall at random
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) sb.check_result(pixel_out, src_col, src_row);
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	task automatic send_pixel(pos_t col, pos_t row, pix_t ul, pix_t ur, pix_t dl,
			pix_t dr);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		out_col <= col;
		out_row <= row;
		pix_up_left <= ul;
		pix_up_right <= ur;
		pix_down_left <= dl;
		pix_down_right <= dr;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sb.note_transfer(col, row, ul, ur, dl, dr);
	endtask

	task automatic drain_pipeline();
		in_valid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
	endtask

	task automatic write_sizes(size_t width, size_t height);
		drain_pipeline();
		cfg_wr_en <= 1'b1;
		cfg_index <= CFG_SRC_BLOCK_WIDTH;
		cfg_data <= width;
		@(posedge clk);
		sb.write_reg(CFG_SRC_BLOCK_WIDTH, width);
		cfg_index <= CFG_SRC_BLOCK_HEIGHT;
		cfg_data <= height;
		@(posedge clk);
		sb.write_reg(CFG_SRC_BLOCK_HEIGHT, height);
		cfg_wr_en <= 1'b0;
	endtask

	function automatic pix_t rand_pix();
		case ($urandom_range(7))
			0: return 8'd0;
			1: return 8'd255;
			default: return pix_t'($urandom_range(255));
		endcase
	endfunction

	task automatic send_random();
		send_pixel(pos_t'($urandom_range(15)), pos_t'($urandom_range(15)),
			rand_pix(), rand_pix(), rand_pix(), rand_pix());
	endtask

	initial begin
		size_t phase_w[9];
		size_t phase_h[9];
		sb = new();
		phase_w = '{5'd5, 5'd16, 5'd0, 5'd31, 5'd4, 5'd7, 5'd0, 5'd0, 5'd16};
		phase_h = '{5'd16, 5'd5, 5'd31, 5'd0, 5'd17, 5'd11, 5'd0, 5'd0, 5'd16};
		phase_w[6] = size_t'($urandom_range(31));
		phase_h[6] = size_t'($urandom_range(31));
		phase_w[7] = size_t'($urandom_range(31));
		phase_h[7] = size_t'($urandom_range(31));

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset sizes equal the block: up-left comes back unchanged
		send_pixel(4'd0, 4'd0, 8'd0, 8'd0, 8'd0, 8'd0);
		send_pixel(4'd15, 4'd15, 8'd255, 8'd255, 8'd255, 8'd255);
		send_pixel(4'd15, 4'd0, 8'd255, 8'd0, 8'd0, 8'd0);
		send_pixel(4'd0, 4'd15, 8'd0, 8'd255, 8'd255, 8'd255);
		send_pixel(4'd7, 4'd9, 8'hAA, 8'h55, 8'hAA, 8'h55);
		send_pixel(4'd3, 4'd12, 8'h55, 8'hAA, 8'h55, 8'hAA);

		// smallest in-range sizes
		write_sizes(5'd5, 5'd5);
		send_pixel(4'd15, 4'd15, 8'd255, 8'd255, 8'd255, 8'd255);
		send_pixel(4'd15, 4'd15, 8'd0, 8'd255, 8'd255, 8'd255);
		send_pixel(4'd1, 4'd14, 8'd255, 8'd0, 8'd0, 8'd255);
		send_pixel(4'd0, 4'd0, 8'd255, 8'd255, 8'd255, 8'd255);
		send_pixel(4'd13, 4'd3, 8'd0, 8'd0, 8'd0, 8'd255);

		// out of range on both sides: clamped
		write_sizes(5'd0, 5'd31);
		send_pixel(4'd15, 4'd15, 8'd255, 8'd0, 8'd255, 8'd0);
		send_pixel(4'd9, 4'd6, 8'd12, 8'd200, 8'd77, 8'd255);
		send_pixel(4'd10, 4'd5, 8'd255, 8'd255, 8'd255, 8'd255);
		write_sizes(5'd17, 5'd4);
		send_pixel(4'd15, 4'd15, 8'd255, 8'd0, 8'd255, 8'd0);
		send_pixel(4'd6, 4'd13, 8'd1, 8'd254, 8'd128, 8'd127);
		send_pixel(4'd11, 4'd11, 8'd255, 8'd255, 8'd255, 8'd255);
		write_sizes(5'd16, 5'd16);
		send_pixel(4'd8, 4'd8, 8'd200, 8'd0, 8'd0, 8'd0);
		send_pixel(4'd15, 4'd1, 8'd0, 8'd255, 8'd255, 8'd255);

		for (int ph = 0; ph < 9; ph++) begin
			write_sizes(phase_w[ph], phase_h[ph]);
			case (ph / 3)
				0: begin
					send_idle_pct <= 26;
					recv_stall_pct <= 59;
				end
				1: begin
					send_idle_pct <= 59;
					recv_stall_pct <= 26;
				end
				default: begin
					send_idle_pct <= 0;
					recv_stall_pct <= 0;
				end
			endcase
			repeat (PHASE_ITEMS) send_random();
		end

		drain_pipeline();
		repeat (20) @(posedge clk);
		if (sb.errors == 0) begin
			$display("tb_top passed");
		end else begin
			$display("tb_top failed");
		end
		$finish;
	end
endmodule

@@ files.f @@
rtl/core/bbu_pkg.sv
rtl/core/bbu_axis_map.sv
rtl/core/bbu_blend.sv
rtl/core/block_bilinear_upscaler_top.sv
verif/tb_top.sv
